FILE: src/hlae_pkg.sv
// ----------------------------------------------------------------------------
// hlae_pkg
// Shared types, character codes and helpers for the HTML link attribute
// extractor.
// ----------------------------------------------------------------------------
package hlae_pkg;

	// Input word: one text byte and its end-of-string mark
	typedef struct packed {
		logic [7:0] text_byte;
		logic       is_last;
	} text_word_t;

	// Output word: copied character, separator or end marker
	typedef struct packed {
		logic [7:0] out_char;
		logic       is_end;
		logic       found_any;
	} link_word_t;

	// Character codes
	localparam logic [7:0] CHAR_LT    = 8'h3C; // <
	localparam logic [7:0] CHAR_GT    = 8'h3E; // >
	localparam logic [7:0] CHAR_QUOTE = 8'h22; // "
	localparam logic [7:0] CHAR_EQ    = 8'h3D; // =
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_UC_A  = 8'h41;
	localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
	localparam logic [7:0] CASE_BIT   = 8'h20;

	// Attribute names, oldest byte in the high lane
	localparam logic [31:0] NAME_HREF = 32'h6872_6566;
	localparam logic [23:0] NAME_SRC  = 24'h73_7263;

	// Word length saturation point
	localparam logic [2:0] LEN_MAX  = 3'd5;
	localparam logic [2:0] LEN_HREF = 3'd4;
	localparam logic [2:0] LEN_SRC  = 3'd3;

	// Space, tab, LF, VT, FF, CR
	function automatic logic is_white(input logic [7:0] c);
		return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
	endfunction

	// Fold A..Z to lower case, everything else unchanged
	function automatic logic [7:0] fold_byte(input logic [7:0] c);
		return ((c >= CHAR_UC_A) && (c <= CHAR_UC_Z)) ? (c | CASE_BIT) : c;
	endfunction

endpackage

FILE: src/html_link_attribute_extractor_unit.sv
// ----------------------------------------------------------------------------
// html_link_attribute_extractor_unit
// Streams HTML text and copies out the quoted values of src and href
// attributes, one character per output word.
// ----------------------------------------------------------------------------
// Usage:
//   byte channel (byte_valid/byte_ready/byte_word) takes one text byte per
//   word; is_last marks the final byte of a string.
//   char channel (char_valid/char_ready/char_word) returns copied value
//   characters, a single space between successive values, and after the
//   last byte an end marker (is_end = 1) whose found_any says whether any
//   character was copied for that string.
// Timing:
//   A byte is registered on acceptance and decoded from that register into a
//   two-entry output queue, whose head entry offers its results. One byte
//   per cycle is sustained while char_ready stays high; a last byte that also
//   copies a character yields two words, which the queue absorbs, so the
//   rate is set by the queue draining one word per cycle.
// Reset clears the parser state, the input stage and the queue. When the
// receiver stalls, the queue fills and byte_ready drops once it has no room
// for the results of the registered byte; nothing is lost.
// ----------------------------------------------------------------------------
module html_link_attribute_extractor_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   byte_valid,
	output logic                   byte_ready,
	input  hlae_pkg::text_word_t   byte_word,
	output logic                   char_valid,
	input  logic                   char_ready,
	output hlae_pkg::link_word_t   char_word
);
	import hlae_pkg::*;

	// Input stage
	logic        valid_s1;
	text_word_t  word_s1;

	// Parser state
	logic        inside_tag_q;
	logic        inside_quote_q;
	logic        copy_value_q;
	logic        word_open_q;
	logic [2:0]  word_len_q;
	logic [31:0] recent_q;
	logic        emitted_any_q;

	// Output queue, entry 0 is the head
	link_word_t  queue_q [2];
	logic [1:0]  count_q;

	// Decode results
	logic        nx_inside_tag, nx_inside_quote, nx_copy_value, nx_word_open;
	logic [2:0]  nx_word_len;
	logic        nx_emitted_any;
	logic        has_char;
	logic [7:0]  res_char;
	logic [1:0]  n_res;
	link_word_t  res0, res1, end_word;
	logic [31:0] folded;
	logic        name_hit;
	logic [7:0]  c;

	logic        pop, fire;
	logic [1:0]  avail;
	logic [2:0]  room_need;

	assign c = word_s1.text_byte;

	// Case-folded history for the attribute name compare
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			folded[8*i +: 8] = fold_byte(recent_q[8*i +: 8]);
		end
	end

	assign name_hit = ((word_len_q == LEN_HREF) && (folded == NAME_HREF)) ||
	                  ((word_len_q == LEN_SRC) && (folded[23:0] == NAME_SRC));

	// Parser next state and character result
	always_comb begin
		nx_inside_tag   = inside_tag_q;
		nx_inside_quote = inside_quote_q;
		nx_copy_value   = copy_value_q;
		nx_word_open    = word_open_q;
		nx_word_len     = word_len_q;
		nx_emitted_any  = emitted_any_q;
		has_char        = 1'b0;
		res_char        = c;
		if (!inside_tag_q) begin
			if (c == CHAR_LT) nx_inside_tag = 1'b1;
		end else if (c == CHAR_QUOTE) begin
			nx_inside_quote = !inside_quote_q;
			if (inside_quote_q) begin
				nx_copy_value = 1'b0;
			end else if (copy_value_q && emitted_any_q) begin
				has_char = 1'b1;
				res_char = CHAR_SPACE;
			end
		end else if (!inside_quote_q) begin
			if (c == CHAR_GT) begin
				nx_inside_tag = 1'b0;
			end else if (is_white(c)) begin
				nx_word_open = 1'b0;
			end else if (c == CHAR_EQ) begin
				if (word_open_q && name_hit) nx_copy_value = 1'b1;
			end else if (!word_open_q) begin
				nx_word_open = 1'b1;
				nx_word_len  = '0;
			end
		end else if (copy_value_q) begin
			has_char       = 1'b1;
			nx_emitted_any = 1'b1;
		end
		// Every byte counts while a word is open
		if (nx_word_open && (nx_word_len < LEN_MAX)) nx_word_len = nx_word_len + 3'd1;
	end

	// Result words for this byte
	always_comb begin
		end_word.out_char  = '0;
		end_word.is_end    = 1'b1;
		end_word.found_any = nx_emitted_any;
		res1               = end_word;
		if (has_char) begin
			res0.out_char  = res_char;
			res0.is_end    = 1'b0;
			res0.found_any = 1'b0;
		end else begin
			res0 = end_word;
		end
		n_res = {1'b0, has_char} + {1'b0, word_s1.is_last};
	end

	// Queue room check
	assign char_valid = (count_q != 2'd0);
	assign char_word  = queue_q[0];
	assign pop        = char_valid && char_ready;
	assign avail      = count_q - {1'b0, pop};
	assign room_need  = {1'b0, avail} + {1'b0, n_res};
	assign fire       = valid_s1 && (room_need <= 3'd2);
	assign byte_ready = !valid_s1 || fire;

	// Input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) word_s1 <= byte_word;
	end

	// Parser state update, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_tag_q   <= 1'b0;
			inside_quote_q <= 1'b0;
			copy_value_q   <= 1'b0;
			word_open_q    <= 1'b0;
			word_len_q     <= '0;
			recent_q       <= '0;
			emitted_any_q  <= 1'b0;
		end else if (fire) begin
			if (word_s1.is_last) begin
				inside_tag_q   <= 1'b0;
				inside_quote_q <= 1'b0;
				copy_value_q   <= 1'b0;
				word_open_q    <= 1'b0;
				word_len_q     <= '0;
				recent_q       <= '0;
				emitted_any_q  <= 1'b0;
			end else begin
				inside_tag_q   <= nx_inside_tag;
				inside_quote_q <= nx_inside_quote;
				copy_value_q   <= nx_copy_value;
				word_open_q    <= nx_word_open;
				word_len_q     <= nx_word_len;
				recent_q       <= {recent_q[23:0], c};
				emitted_any_q  <= nx_emitted_any;
			end
		end
	end

	// Output queue: shift on pop, append new results behind survivors
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= fire ? (avail + n_res) : avail;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && (n_res != 2'd0) && (avail == 2'd0)) begin
			queue_q[0] <= res0;
			queue_q[1] <= res1;
		end else begin
			if (pop) queue_q[0] <= queue_q[1];
			// one survivor left: new word goes behind it
			if (fire && (n_res != 2'd0)) queue_q[1] <= res0;
		end
	end

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2) else $error("output queue overfilled");

	a_char_no_found: assert property (@(posedge clk) disable iff (!arst_n)
		(char_valid && !char_word.is_end) |-> !char_word.found_any)
		else $error("found_any set on a character word");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> byte_ready) else $error("input stalled with empty stage");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && word_s1.is_last) |=> (!inside_tag_q && !emitted_any_q))
		else $error("state not cleared after last byte");

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the HTML link attribute extractor. Text strings
// are streamed in a byte at a time, from a short directed set first and then
// from random markup built mostly of well-formed tags with src/href style
// attributes, near-miss names, odd white space and broken strings. A local
// parser model predicts every output word; a monitor checks the words in
// order. Both channels idle at random, and one phase holds the char channel
// off long enough to back the block up onto its byte input.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import hlae_pkg::*;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int LONG_STALL_LEN  = 300;
	localparam int DRAIN_CYCLES    = 20;
	localparam logic [7:0] BLANK_CODES [6] = '{CHAR_SPACE, CHAR_TAB, 8'h0A, 8'h0B, 8'h0C,
		CHAR_CR};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_ready;
	text_word_t  byte_word = '0;
	logic        char_valid;
	logic        char_ready = 1'b0;
	link_word_t  char_word;

	// run control
	int cycle_count = 0;
	int error_count = 0;
	int items_sent = 0;
	int send_idle_pct = 19;
	int recv_idle_pct = 60;
	bit long_stall = 1'b0;
	int stall_cycles = 0;

	// parser model state
	logic        in_tag, in_quote, copying, word_live, any_copied;
	logic [2:0]  word_len;
	logic [31:0] recent4;

	link_word_t  expected_chars [$];
	logic [7:0]  text_buf [$];

	html_link_attribute_extractor_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_word  (byte_word),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_word  (char_word)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic flag_mismatch(input string what);
		$display("tb: mismatch at cycle %0d: %s", cycle_count, what);
		error_count++;
	endtask

	// ---------------------------------------------------------------- model

	function automatic logic is_blank(input logic [7:0] c);
		return c inside {CHAR_SPACE, [CHAR_TAB:CHAR_CR]};
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c inside {[CHAR_UC_A:CHAR_UC_Z]}) ? c + 8'h20 : c;
	endfunction

	function automatic link_word_t link_word(input logic [7:0] c, input logic e,
			input logic f);
		link_word_t w;
		w.out_char  = c;
		w.is_end    = e;
		w.found_any = f;
		return w;
	endfunction

	task automatic clear_parser();
		in_tag     = 1'b0;
		in_quote   = 1'b0;
		copying    = 1'b0;
		word_live  = 1'b0;
		any_copied = 1'b0;
		word_len   = '0;
		recent4    = '0;
	endtask

	// Advance the parser by one accepted byte and queue the words it yields
	task automatic extract_links(input logic [7:0] c, input logic last);
		logic [31:0] low4;
		logic        name_hit;
		low4 = {to_lower(recent4[31:24]), to_lower(recent4[23:16]),
			to_lower(recent4[15:8]), to_lower(recent4[7:0])};
		name_hit = (word_len == LEN_HREF && low4 == NAME_HREF) ||
			(word_len == LEN_SRC && low4[23:0] == NAME_SRC);

		if (!in_tag) begin
			if (c == CHAR_LT)
				in_tag = 1'b1;
		end else if (c == CHAR_QUOTE) begin
			in_quote = !in_quote;
			if (!in_quote)
				copying = 1'b0;
			else if (copying && any_copied)
				expected_chars.push_back(link_word(CHAR_SPACE, 1'b0, 1'b0));
		end else if (!in_quote) begin
			if (c == CHAR_GT)
				in_tag = 1'b0;
			else if (is_blank(c))
				word_live = 1'b0;
			else if (c == CHAR_EQ) begin
				if (word_live && name_hit)
					copying = 1'b1;
			end else if (!word_live) begin
				word_live = 1'b1;
				word_len  = '0;
			end
		end else if (copying) begin
			expected_chars.push_back(link_word(c, 1'b0, 1'b0));
			any_copied = 1'b1;
		end

		// word length counts every byte while a word is open
		if (word_live && word_len < LEN_MAX)
			word_len++;
		recent4 = {recent4[23:0], c};

		if (last) begin
			expected_chars.push_back(link_word(8'h00, 1'b1, any_copied));
			clear_parser();
		end
	endtask

	// ------------------------------------------------------------ channels

	// Offer one byte, optionally after random idle cycles, and wait for it
	task automatic push_byte(input logic [7:0] c, input logic last);
		text_word_t w;
		w.text_byte = c;
		w.is_last   = last;
		while ($urandom_range(99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_word  <= w;
		do
			@(posedge clk);
		while (byte_ready !== 1'b1);
		extract_links(c, last);
		items_sent++;
	endtask

	task automatic send_text();
		foreach (text_buf[i])
			push_byte(text_buf[i], i == text_buf.size() - 1);
	endtask

	// Receiver: random ready, or a long hold-off when asked
	always @(posedge clk) begin
		if (long_stall && stall_cycles < LONG_STALL_LEN) begin
			char_ready   <= 1'b0;
			stall_cycles <= stall_cycles + 1;
		end else begin
			char_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Output monitor: compare each taken word with the oldest prediction
	always @(posedge clk) begin
		link_word_t want;
		if (arst_n && char_valid === 1'b1 && char_ready) begin
			if (expected_chars.size() == 0) begin
				flag_mismatch($sformatf("unexpected word char=%h end=%b found=%b",
					char_word.out_char, char_word.is_end, char_word.found_any));
			end else begin
				want = expected_chars.pop_front();
				if (char_word.out_char !== want.out_char)
					flag_mismatch($sformatf("out_char %h, want %h",
						char_word.out_char, want.out_char));
				if (char_word.is_end !== want.is_end)
					flag_mismatch($sformatf("is_end %b, want %b",
						char_word.is_end, want.is_end));
				if (char_word.found_any !== want.found_any)
					flag_mismatch($sformatf("found_any %b, want %b",
						char_word.found_any, want.found_any));
			end
		end
	end

	// ------------------------------------------------------- text builders

	function automatic logic [7:0] any_byte();
		return 8'($urandom_range(255, 1));
	endfunction

	function automatic logic [7:0] mixed_case(input logic [7:0] c);
		if (c inside {[8'h61:8'h7A]} && $urandom_range(1))
			return c ^ CASE_BIT;
		return c;
	endfunction

	function automatic logic [7:0] rand_letter();
		return mixed_case(8'($urandom_range(8'h7A, 8'h61)));
	endfunction

	function automatic logic [7:0] pick_blank();
		return BLANK_CODES[$urandom_range(5)];
	endfunction

	task automatic append_str(input string s, input bit vary_case);
		for (int i = 0; i < s.len(); i++)
			text_buf.push_back(vary_case ? mixed_case(s[i]) : s[i]);
	endtask

	// One string: mostly tags with attributes, some loose text, some cut short
	task automatic compose_markup();
		int cut;
		logic [7:0] v;
		text_buf.delete();
		repeat ($urandom_range(3, 1)) begin
			if ($urandom_range(9) < 8) begin
				text_buf.push_back(CHAR_LT);
				repeat ($urandom_range(3, 1))
					text_buf.push_back(rand_letter());
				repeat ($urandom_range(3)) begin
					text_buf.push_back(pick_blank());
					// attribute name: real ones, near misses, random words
					case ($urandom_range(11))
						0, 1, 2:  append_str("href", 1);
						3, 4, 5:  append_str("src", 1);
						6:        append_str("hre", 1);
						7:        append_str("xsrc", 1);
						8:        append_str("hrefs", 1);
						9:        append_str("sr", 1);
						default: repeat ($urandom_range(6, 1))
							text_buf.push_back(rand_letter());
					endcase
					if ($urandom_range(7) == 0)
						text_buf.push_back(pick_blank());
					text_buf.push_back(CHAR_EQ);
					if ($urandom_range(9) == 0)
						text_buf.push_back(any_byte());
					// quoted value, sometimes left open
					text_buf.push_back(CHAR_QUOTE);
					repeat ($urandom_range(5)) begin
						v = $urandom_range(1) ? rand_letter() : any_byte();
						text_buf.push_back(v == CHAR_QUOTE ? 8'hFF : v);
					end
					if ($urandom_range(11) != 0)
						text_buf.push_back(CHAR_QUOTE);
				end
				if ($urandom_range(3) == 0)
					text_buf.push_back(pick_blank());
				text_buf.push_back(CHAR_GT);
			end else begin
				repeat ($urandom_range(4, 1))
					text_buf.push_back(any_byte());
			end
		end
		// broken string: last byte falls anywhere
		if ($urandom_range(15) == 0) begin
			cut = $urandom_range(text_buf.size(), 1);
			while (text_buf.size() > cut)
				void'(text_buf.pop_back());
		end
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_directed();
		// lone lowest byte: nothing found
		text_buf.delete();
		text_buf.push_back(8'h01);
		send_text();
		// upper-case tag name as the word; last byte copies 0xFF, then the marker
		text_buf.delete();
		append_str("<SRC=\"", 0);
		text_buf.push_back(8'hFF);
		send_text();
		// mixed-case href, VT as white space, two values joined by a space
		text_buf.delete();
		append_str("<HrEf=\"y\"", 0);
		text_buf.push_back(8'h0B);
		append_str("src=\"z\">", 0);
		send_text();
	endtask

	task automatic test_random_markup(input int goal);
		while (items_sent < goal) begin
			compose_markup();
			send_text();
		end
	endtask

	// Receiver holds off while the sender keeps offering bytes
	task automatic test_long_stall(input int goal);
		send_idle_pct = 0;
		long_stall    = 1'b1;
		test_random_markup(goal);
		long_stall    = 1'b0;
	endtask

	initial begin
		clear_parser();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 19;
		recv_idle_pct = 60;
		test_directed();
		test_random_markup(items_sent + 330);

		send_idle_pct = 60;
		recv_idle_pct = 19;
		test_random_markup(items_sent + 330);

		recv_idle_pct = 0;
		test_long_stall(items_sent + 60);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_markup(items_sent + 330);

		byte_valid <= 1'b0;
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: html_link_attribute_extractor_unit.f
src/hlae_pkg.sv
src/html_link_attribute_extractor_unit.sv
sim/tb_top.sv
